/* hw/rtl/extended_gcd_macros.svh */
// Assertion macros used by the extended GCD top level.
`ifndef EXTENDED_GCD_MACROS_SVH
`define EXTENDED_GCD_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EGCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("extended_gcd: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define EGCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("extended_gcd: next-cycle check failed");

`endif

/* hw/rtl/egcd_pkg.sv */
// Types shared by the extended GCD block: sequencer states, divider control and divider status.
`default_nettype none
package egcd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } egcd_state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/egcd_if.sv */
// Valid/ready channel interfaces for the operand request and the result.
`default_nettype none
interface egcd_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] a;
  logic [W-1:0] b;

  modport source (output valid, a, b, input ready);
  modport sink (input valid, a, b, output ready);
endinterface

interface egcd_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic [W-1:0]        gcd;
  logic signed [W:0]   coef_x;
  logic signed [W:0]   coef_y;

  modport source (output valid, gcd, coef_x, coef_y, input ready);
  modport sink (input valid, gcd, coef_x, coef_y, output ready);
endinterface
`default_nettype wire

/* hw/rtl/egcd_div.sv */
// Restoring shift-subtract divider that also accumulates quotient times two coefficients.
`default_nettype none
module egcd_div #(
  parameter int N = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire egcd_pkg::div_ctrl_t ctrl,
  input  wire logic [N-1:0]       dividend,
  input  wire logic [N-1:0]       divisor,
  input  wire logic [N:0]         mult_x,
  input  wire logic [N:0]         mult_y,
  output egcd_pkg::div_stat_t     stat,
  output logic [N-1:0]            rem,
  output logic [N:0]              prod_x,
  output logic [N:0]              prod_y
);

  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [N-1:0]  dvd;
  logic [N+1:0]  diff;
  logic          ge;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    diff = {1'b0, rem, dvd[N-1]} - {2'b00, divisor};
    ge   = ~diff[N+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The products are kept modulo 2^(N+1), which is all the coefficients need.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem    <= '0;
      dvd    <= dividend;
      prod_x <= '0;
      prod_y <= '0;
    end else if (busy) begin
      rem    <= ge ? diff[N-1:0] : {rem[N-2:0], dvd[N-1]};
      dvd    <= {dvd[N-2:0], 1'b0};
      prod_x <= {prod_x[N-1:0], 1'b0} + (ge ? mult_x : '0);
      prod_y <= {prod_y[N-1:0], 1'b0} + (ge ? mult_y : '0);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

/* hw/rtl/extended_gcd.sv */
// Extended GCD top level: sequencer, Euclid state registers and result register.
//
//   channel    dir  payload                         accepted when
//   operands   in   a, b                            valid && ready
//   result     out  gcd, coef_x, coef_y             valid && ready
//
// Each Euclid round runs one division in the shared shift-subtract divider; with b zero
// no division is run. For 16-bit operands there are at most about 23 rounds.
// The result register holds a finished result until taken; a new request is
// accepted once the block is idle, even while that result waits.
// Synchronous reset clears the sequencer, the divider's busy, done and count registers and the result valid flag only.
`default_nettype none
`include "extended_gcd_macros.svh"
module extended_gcd #(
  parameter int OPERAND_BITS = 16
) (
  input wire logic         clk,
  input wire logic         rst,
  egcd_in_if.sink          operands,
  egcd_out_if.source       result
);

  localparam int N = OPERAND_BITS;

  egcd_pkg::egcd_state_t state, state_next;
  egcd_pkg::div_ctrl_t   div_ctrl;
  egcd_pkg::div_stat_t   div_stat;

  logic [N-1:0] num;
  logic [N-1:0] den;
  logic [N:0]   xo, xn, yo, yn;
  logic [N-1:0] div_rem;
  logic [N:0]   prod_x, prod_y;

  logic         res_valid;
  logic [N-1:0] res_gcd;
  logic [N:0]   res_x;
  logic [N:0]   res_y;

  logic accept;
  logic load_res;

  egcd_div #(.N(N)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (num),
    .divisor  (den),
    .mult_x   (xn),
    .mult_y   (yn),
    .stat     (div_stat),
    .rem      (div_rem),
    .prod_x   (prod_x),
    .prod_y   (prod_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_ctrl.start = 1'b0;
    load_res       = 1'b0;
    operands.ready = 1'b0;
    accept         = 1'b0;
    unique case (state)
      egcd_pkg::ST_IDLE: begin
        operands.ready = 1'b1;
        accept         = operands.valid;
        if (operands.valid) begin
          state_next = egcd_pkg::ST_CHECK;
        end
      end
      egcd_pkg::ST_CHECK: begin
        if (den == '0) begin
          state_next = egcd_pkg::ST_FINISH;
        end else begin
          div_ctrl.start = 1'b1;
          state_next     = egcd_pkg::ST_DIV;
        end
      end
      egcd_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = egcd_pkg::ST_CHECK;
        end
      end
      egcd_pkg::ST_FINISH: begin
        if (!res_valid || result.ready) begin
          load_res   = 1'b1;
          state_next = egcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = egcd_pkg::ST_IDLE;
      end
    endcase
  end

  // Round update: (num, den) becomes (den, rem) and each pair shifts with new = old - q*newer.
  always_ff @(posedge clk) begin
    if (accept) begin
      num <= operands.a;
      den <= operands.b;
      xo  <= (N+1)'(1);
      xn  <= '0;
      yo  <= '0;
      yn  <= (N+1)'(1);
    end else if (state == egcd_pkg::ST_DIV && div_stat.done) begin
      num <= den;
      den <= div_rem;
      xo  <= xn;
      xn  <= xo - prod_x;
      yo  <= yn;
      yn  <= yo - prod_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_gcd <= num;
      res_x   <= xo;
      res_y   <= yo;
    end
  end

  assign result.valid  = res_valid;
  assign result.gcd    = res_gcd;
  assign result.coef_x = res_x;
  assign result.coef_y = res_y;

  `EGCD_ASSERT_NOW(a_start_nonzero_den, div_ctrl.start, den != '0)
  `EGCD_ASSERT_NOW(a_done_in_div, div_stat.done, state == egcd_pkg::ST_DIV && !div_stat.busy)
  `EGCD_ASSERT_NOW(a_load_only_free, load_res, !res_valid || result.ready)
  `EGCD_ASSERT_NEXT(a_accept_to_check, accept, state == egcd_pkg::ST_CHECK)
  `EGCD_ASSERT_NEXT(a_start_busy, div_ctrl.start, div_stat.busy)

endmodule
`default_nettype wire
